// File: src/clns_pkg.sv
// constants, control word type and control store for the character display nibble sequencer
package clns_pkg;

    localparam int NUM_COLS      = 16;
    localparam int NUM_ROWS      = 2;
    localparam int MAX_PAD_CHARS = 16;

    localparam int COL_W = $clog2(NUM_COLS + 1);
    localparam int PAD_W = $clog2(MAX_PAD_CHARS + 1);
    localparam int PC_W  = 5;

    // request kinds
    localparam logic [2:0] REQ_INIT      = 3'd0;
    localparam logic [2:0] REQ_COMMAND   = 3'd1;
    localparam logic [2:0] REQ_CHAR      = 3'd2;
    localparam logic [2:0] REQ_CURSOR    = 3'd3;
    localparam logic [2:0] REQ_CLEAR     = 3'd4;
    localparam logic [2:0] REQ_DISPLAY   = 3'd5;
    localparam logic [2:0] REQ_BACKLIGHT = 3'd6;
    localparam logic [2:0] REQ_PAD       = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_STROBE    = 2'd0;
    localparam logic [1:0] KIND_BACKLIGHT = 2'd1;
    localparam logic [1:0] KIND_REJECT    = 2'd2;

    // display command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_DISPLAY  = 8'h08;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // nibble source select
    localparam logic [1:0] NS_CONST = 2'd0;
    localparam logic [1:0] NS_HI    = 2'd1;
    localparam logic [1:0] NS_LO    = 2'd2;

    // program entry points
    localparam logic [PC_W-1:0] PC_INIT   = 5'd0;
    localparam logic [PC_W-1:0] PC_BYTE   = 5'd16;
    localparam logic [PC_W-1:0] PC_CHAR   = 5'd18;
    localparam logic [PC_W-1:0] PC_PAD    = 5'd20;
    localparam logic [PC_W-1:0] PC_REJECT = 5'd22;
    localparam logic [PC_W-1:0] PC_BLIGHT = 5'd23;
    localparam logic [PC_W-1:0] PC_LAST   = 5'd23;

    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      nsel;
        logic [3:0]      nib;
        logic            rs;
        logic [2:0]      delay;
        logic            colinc;
        logic            last;
        logic            jmp;
        logic [PC_W-1:0] target;
    } t_ctl;

    function automatic t_ctl mk_ctl(input logic [1:0] kind, input logic [1:0] nsel,
                                    input logic [3:0] nib, input logic rs,
                                    input logic [2:0] delay, input logic colinc,
                                    input logic last, input logic jmp,
                                    input logic [PC_W-1:0] target);
        t_ctl w;
        w.kind   = kind;
        w.nsel   = nsel;
        w.nib    = nib;
        w.rs     = rs;
        w.delay  = delay;
        w.colinc = colinc;
        w.last   = last;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    function automatic t_ctl ctl_rom(input logic [PC_W-1:0] pc);
        t_ctl w;
        case (pc)
            // init: wake-up nibbles, then function set, display off, clear,
            // entry mode, display on, home address
            5'd0:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h3, 1'b0, 3'd5, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd1:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h3, 1'b0, 3'd1, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd2:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h3, 1'b0, 3'd1, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd3:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h2, 1'b0, 3'd1, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd4:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h2, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd5:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h8, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd6:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h0, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd7:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h8, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd8:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h0, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd9:  w = mk_ctl(KIND_STROBE, NS_CONST, 4'h1, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd10: w = mk_ctl(KIND_STROBE, NS_CONST, 4'h0, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd11: w = mk_ctl(KIND_STROBE, NS_CONST, 4'h6, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd12: w = mk_ctl(KIND_STROBE, NS_CONST, 4'h0, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd13: w = mk_ctl(KIND_STROBE, NS_CONST, 4'hC, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd14: w = mk_ctl(KIND_STROBE, NS_CONST, 4'h8, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd15: w = mk_ctl(KIND_STROBE, NS_CONST, 4'h0, 1'b0, 3'd0, 1'b0, 1'b1, 1'b0, PC_INIT);
            // instruction byte
            5'd16: w = mk_ctl(KIND_STROBE, NS_HI, 4'h0, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd17: w = mk_ctl(KIND_STROBE, NS_LO, 4'h0, 1'b0, 3'd0, 1'b0, 1'b1, 1'b0, PC_INIT);
            // data byte
            5'd18: w = mk_ctl(KIND_STROBE, NS_HI, 4'h0, 1'b1, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd19: w = mk_ctl(KIND_STROBE, NS_LO, 4'h0, 1'b1, 3'd0, 1'b1, 1'b1, 1'b0, PC_INIT);
            // pad loop
            5'd20: w = mk_ctl(KIND_STROBE, NS_HI, 4'h0, 1'b1, 3'd0, 1'b0, 1'b0, 1'b0, PC_INIT);
            5'd21: w = mk_ctl(KIND_STROBE, NS_LO, 4'h0, 1'b1, 3'd0, 1'b1, 1'b1, 1'b1, PC_PAD);
            5'd22: w = mk_ctl(KIND_REJECT, NS_CONST, 4'h0, 1'b0, 3'd0, 1'b0, 1'b1, 1'b0, PC_INIT);
            5'd23: w = mk_ctl(KIND_BACKLIGHT, NS_CONST, 4'h0, 1'b0, 3'd0, 1'b0, 1'b1, 1'b0,
                              PC_INIT);
            default: w = mk_ctl(KIND_REJECT, NS_CONST, 4'h0, 1'b0, 3'd0, 1'b0, 1'b1, 1'b0,
                                PC_INIT);
        endcase
        return w;
    endfunction

endpackage

// File: src/char_lcd_nibble_sequencer.sv
// character display nibble sequencer: control store program driving the nibble datapath
// first result: acceptance sets the step counter; its word is loaded into the output register
//   once that register is empty or being taken. throughput: one result per cycle from the step
//   counter walking the control store while the output is not stalled; an item has 1 to 32
//   results, and the next item is accepted only after its predecessor's last result is loaded
// reset: synchronous active low; clears ready flag, backlight, cursor and the sequencer
module char_lcd_nibble_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // byte_value, column, row, disp_en, curs_en,
                                       // blink_en, backlight_on
    input  logic [2:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // nibble_value, reg_select, backlight_pin, wait_ms,
                                       // cursor_col, cursor_row
    output logic [1:0]  m_axis_tuser,  // result_kind
    output logic        m_axis_tlast
);

    localparam int COL_W = clns_pkg::COL_W;
    localparam int PAD_W = clns_pkg::PAD_W;
    localparam int PC_W  = clns_pkg::PC_W;

    logic                  r_ready, n_ready;
    logic                  r_bl, n_bl;
    logic [COL_W-1:0]      r_col, n_col;
    logic                  r_row, n_row;
    logic                  r_busy, n_busy;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [PAD_W-1:0]      r_padk, n_padk;
    logic [7:0]            r_byte, n_byte;
    logic                  r_ovalid, n_ovalid;
    logic [1:0]            r_okind, n_okind;
    logic [3:0]            r_onib, n_onib;
    logic                  r_ors, n_ors;
    logic                  r_obl, n_obl;
    logic [2:0]            r_odelay, n_odelay;
    logic [COL_W-1:0]      r_ocol, n_ocol;
    logic                  r_orow, n_orow;
    logic                  r_olast, n_olast;

    clns_pkg::t_ctl        w;
    logic                  accept, load, take_jmp, w_last;
    logic [COL_W-1:0]      col_inc, clamp_col;
    logic [PAD_W-1:0]      padk_inc;
    logic                  clamp_row;
    logic [2:0]            req;
    logic [7:0]            in_byte, in_col, in_row;
    logic [3:0]            nib;

    assign req     = s_axis_tuser;
    assign in_byte = s_axis_tdata[7:0];
    assign in_col  = s_axis_tdata[15:8];
    assign in_row  = s_axis_tdata[23:16];

    assign s_axis_tready = !r_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load          = r_busy && (!r_ovalid || m_axis_tready);

    assign w         = clns_pkg::ctl_rom(r_pc);
    assign col_inc   = r_col + COL_W'(1);
    assign padk_inc  = r_padk + PAD_W'(1);
    assign take_jmp  = w.jmp && (col_inc < COL_W'(clns_pkg::NUM_COLS))
                       && (padk_inc < PAD_W'(clns_pkg::MAX_PAD_CHARS));
    assign w_last    = w.last && !take_jmp;
    assign clamp_col = (in_col < 8'(clns_pkg::NUM_COLS)) ? COL_W'(in_col) : '0;
    assign clamp_row = (in_row < 8'(clns_pkg::NUM_ROWS)) ? in_row[0] : 1'b0;

    always_comb begin
        case (w.nsel)
            clns_pkg::NS_HI: nib = r_byte[7:4];
            clns_pkg::NS_LO: nib = r_byte[3:0];
            default:         nib = w.nib;
        endcase
    end

    always_comb begin
        n_ready  = r_ready;
        n_bl     = r_bl;
        n_col    = r_col;
        n_row    = r_row;
        n_busy   = r_busy;
        n_pc     = r_pc;
        n_padk   = r_padk;
        n_byte   = r_byte;
        n_ovalid = r_ovalid;
        n_okind  = r_okind;
        n_onib   = r_onib;
        n_ors    = r_ors;
        n_obl    = r_obl;
        n_odelay = r_odelay;
        n_ocol   = r_ocol;
        n_orow   = r_orow;
        n_olast  = r_olast;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        if (load) begin
            n_ovalid = 1'b1;
            n_okind  = w.kind;
            n_onib   = nib;
            n_ors    = w.rs;
            n_obl    = r_bl;
            n_odelay = w.delay;
            n_ocol   = w.colinc ? col_inc : r_col;
            n_orow   = r_row;
            n_olast  = w_last;
            if (w.colinc) begin
                n_col = col_inc;
            end
            if (w.jmp) begin
                n_padk = padk_inc;
            end
            n_pc = take_jmp ? w.target : r_pc + PC_W'(1);
            if (w_last) begin
                n_busy = 1'b0;
            end
        end

        if (accept) begin
            n_busy = 1'b1;
            n_padk = '0;
            n_byte = in_byte;
            if (req != clns_pkg::REQ_INIT && !r_ready) begin
                n_pc = clns_pkg::PC_REJECT;
            end else begin
                case (req)
                    clns_pkg::REQ_INIT: begin
                        n_pc    = clns_pkg::PC_INIT;
                        n_ready = 1'b1;
                        n_bl    = 1'b1;
                        n_col   = '0;
                        n_row   = 1'b0;
                    end
                    clns_pkg::REQ_COMMAND: begin
                        n_pc = clns_pkg::PC_BYTE;
                    end
                    clns_pkg::REQ_CHAR: begin
                        n_pc = (r_col >= COL_W'(clns_pkg::NUM_COLS)) ? clns_pkg::PC_REJECT
                                                                     : clns_pkg::PC_CHAR;
                    end
                    clns_pkg::REQ_CURSOR: begin
                        n_pc   = clns_pkg::PC_BYTE;
                        n_col  = clamp_col;
                        n_row  = clamp_row;
                        n_byte = clns_pkg::CMD_SET_ADDR | {1'b0, clamp_row, 6'(clamp_col)};
                    end
                    clns_pkg::REQ_CLEAR: begin
                        n_pc   = clns_pkg::PC_BYTE;
                        n_col  = '0;
                        n_row  = 1'b0;
                        n_byte = clns_pkg::CMD_CLEAR;
                    end
                    clns_pkg::REQ_DISPLAY: begin
                        n_pc   = clns_pkg::PC_BYTE;
                        n_byte = clns_pkg::CMD_DISPLAY
                                 | {5'd0, s_axis_tdata[24], s_axis_tdata[25], s_axis_tdata[26]};
                    end
                    clns_pkg::REQ_BACKLIGHT: begin
                        n_pc = clns_pkg::PC_BLIGHT;
                        n_bl = s_axis_tdata[27];
                    end
                    default: begin
                        n_byte = clns_pkg::CHAR_SPACE;
                        n_pc   = (r_col >= COL_W'(clns_pkg::NUM_COLS)) ? clns_pkg::PC_REJECT
                                                                       : clns_pkg::PC_PAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_bl     <= 1'b0;
            r_col    <= '0;
            r_row    <= 1'b0;
            r_busy   <= 1'b0;
            r_pc     <= clns_pkg::PC_INIT;
            r_padk   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ready  <= n_ready;
            r_bl     <= n_bl;
            r_col    <= n_col;
            r_row    <= n_row;
            r_busy   <= n_busy;
            r_pc     <= n_pc;
            r_padk   <= n_padk;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_okind  <= n_okind;
        r_onib   <= n_onib;
        r_ors    <= n_ors;
        r_obl    <= n_obl;
        r_odelay <= n_odelay;
        r_ocol   <= n_ocol;
        r_orow   <= n_orow;
        r_olast  <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {1'b0, r_orow, r_ocol[4:0], r_odelay, r_obl, r_ors, r_onib};

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= clns_pkg::PC_LAST)
        else $error("step counter outside control store");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(clns_pkg::NUM_COLS))
        else $error("tracked column past display width");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_okind != clns_pkg::KIND_STROBE) |-> r_olast)
        else $error("non-strobe result not final");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && w_last) |=> !r_busy)
        else $error("sequencer busy after final result");

    a_delay_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odelay != 3'd0) |-> r_ready)
        else $error("init wait shown while not initialized");

endmodule
